[hdl/radp_pkg.sv]
// shared widths, register indexes, character codes and digit decode for the radix parser
`default_nettype none
package radp_pkg;

	localparam int CH_W     = 8;
	localparam int VALUE_W  = 64;
	localparam int OFFS_W   = 16;
	localparam int BASE_W   = 6;
	localparam int DIGIT_W  = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RADIX  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED = 1'd1;

	// end offset saturation point
	localparam logic [OFFS_W-1:0] OFFS_CAP = 16'hFFFF;

	// character codes
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_A_LO  = 8'h61;
	localparam logic [CH_W-1:0] CH_F_LO  = 8'h66;
	localparam logic [CH_W-1:0] CH_A_UP  = 8'h41;
	localparam logic [CH_W-1:0] CH_F_UP  = 8'h46;
	localparam logic [CH_W-1:0] CH_X_LO  = 8'h78;
	localparam logic [CH_W-1:0] CH_X_UP  = 8'h58;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;

	localparam logic [DIGIT_W-1:0] NO_DIGIT = 7'd64;

	// digit value of a character, NO_DIGIT when it is not 0-9, a-f, A-F
	function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
		logic [CH_W-1:0] t;
		t = {1'b0, NO_DIGIT};
		if (c >= CH_ZERO && c <= CH_NINE) begin
			t = c - CH_ZERO;
		end else if (c >= CH_A_LO && c <= CH_F_LO) begin
			t = c - CH_A_LO + 8'd10;
		end else if (c >= CH_A_UP && c <= CH_F_UP) begin
			t = c - CH_A_UP + 8'd10;
		end
		return t[DIGIT_W-1:0];
	endfunction

endpackage
`default_nettype wire

[hdl/radp_ifs.sv]
// valid/ready channel interfaces for the radix parser: characters, results, register writes
`default_nettype none
interface radp_in_if;
	logic                        valid;
	logic                        ready;
	logic [radp_pkg::CH_W-1:0]   ch;
	logic                        start_req;

	modport source (output valid, ch, start_req, input ready);
	modport sink (input valid, ch, start_req, output ready);
endinterface

interface radp_out_if;
	logic                          valid;
	logic                          ready;
	logic [radp_pkg::VALUE_W-1:0]  value;
	logic                          ended;
	logic [radp_pkg::OFFS_W-1:0]   end_offset;
	logic [radp_pkg::BASE_W-1:0]   base_in_use;

	modport source (output valid, value, ended, end_offset, base_in_use, input ready);
	modport sink (input valid, value, ended, end_offset, base_in_use, output ready);
endinterface

interface radp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [radp_pkg::CFG_IDX_W-1:0]  index;
	logic [radp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/radix_integer_parser.sv]
// radix_integer_parser: streaming string to 64-bit integer converter
//
// channels: "in" carries one character per transfer plus start_req, which
// marks the first character of a new string. "out" carries one result per
// input transfer: the value so far (negated after a minus sign), ended,
// the end offset (characters consumed, saturating) and the base in use.
// "cfg" writes radix (index 0, 0 = detect from prefix) and signed_mode
// (index 1); write only while the block is idle.
// path: a character taken is registered in the input register, and its
// result is registered in the result register and shown on "out" from then on.
// throughput: one character per cycle while "out" does not stall; the loop
// that sets it is the accumulator update acc*base+digit (64 by 6 bit
// multiply plus add) that feeds the next character through acc_q.
// stall: the result register holds while out.ready is low; the input
// register takes one more character, then in.ready drops.
// reset: arst_n empties both stages and sets radix 0, unsigned mode, parser
// idle with value 0; an item without start_req while idle reports ended.
`default_nettype none
module radix_integer_parser (
	input  wire         clk,
	input  wire         arst_n,
	radp_in_if.sink     in,
	radp_out_if.source  out,
	radp_cfg_if.sink    cfg
);

	// parser phases
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_PREFIX    = 3'd1;
	localparam logic [2:0] PH_ZERO_AUTO = 3'd2;
	localparam logic [2:0] PH_ZERO_X    = 3'd3;
	localparam logic [2:0] PH_ZERO_HEX  = 3'd4;
	localparam logic [2:0] PH_DIGITS    = 3'd5;
	localparam logic [2:0] PH_DONE      = 3'd6;

	localparam logic [radp_pkg::BASE_W-1:0] BASE_8  = 6'd8;
	localparam logic [radp_pkg::BASE_W-1:0] BASE_10 = 6'd10;
	localparam logic [radp_pkg::BASE_W-1:0] BASE_16 = 6'd16;

	// configuration registers
	logic [radp_pkg::BASE_W-1:0]  radix_q;
	logic                         signed_q;

	// input register stage
	logic                         v_s1;
	logic [radp_pkg::CH_W-1:0]    ch_s1;
	logic                         start_s1;

	// parser state
	logic [2:0]                   phase_q;
	logic [radp_pkg::VALUE_W-1:0] acc_q;
	logic [radp_pkg::BASE_W-1:0]  base_q;
	logic                         neg_q;
	logic [radp_pkg::OFFS_W-1:0]  cons_q;

	// result register stage, value kept before negation
	logic                         v_s2;
	logic [radp_pkg::VALUE_W-1:0] acc_s2;
	logic                         neg_s2;
	logic                         ended_s2;
	logic [radp_pkg::OFFS_W-1:0]  cons_s2;
	logic [radp_pkg::BASE_W-1:0]  base_s2;

	logic adv;

	// next state logic
	logic [2:0]                   ph_w, ph_n;
	logic [radp_pkg::VALUE_W-1:0] acc_w, acc_n;
	logic [radp_pkg::BASE_W-1:0]  base_w, base_n;
	logic                         neg_n;
	logic [radp_pkg::OFFS_W-1:0]  cons_w, cons_n, cons_b1, cons_b2;
	logic                         work;
	logic                         is_x;
	logic [radp_pkg::DIGIT_W-1:0] dig;
	logic                         tk_en;
	logic [radp_pkg::BASE_W-1:0]  tk_base;
	logic [radp_pkg::VALUE_W+radp_pkg::BASE_W-1:0] prod;

	// the second stage moves when the result register is free or being taken
	assign adv      = v_s1 && (!v_s2 || out.ready);
	assign in.ready = !v_s1 || adv;
	assign cfg.ready = 1'b1;

	assign out.valid       = v_s2;
	assign out.value       = neg_s2 ? (radp_pkg::VALUE_W'(0) - acc_s2) : acc_s2;
	assign out.ended       = ended_s2;
	assign out.end_offset  = cons_s2;
	assign out.base_in_use = base_s2;

	assign dig  = radp_pkg::digit_of(ch_s1);
	assign is_x = (ch_s1 == radp_pkg::CH_X_LO) || (ch_s1 == radp_pkg::CH_X_UP);

	// saturating single and double count bumps from the working count
	assign cons_b1 = (cons_w < radp_pkg::OFFS_CAP) ? cons_w + 16'd1 : cons_w;
	assign cons_b2 = (cons_b1 < radp_pkg::OFFS_CAP) ? cons_b1 + 16'd1 : cons_b1;

	// one shared multiply for every digit accepted through tk_en; the digit is added below
	assign prod = {{radp_pkg::BASE_W{1'b0}}, acc_w} * {{radp_pkg::VALUE_W{1'b0}}, tk_base};

	always_comb begin
		// a start character clears the state before the phase logic
		ph_w   = start_s1 ? PH_PREFIX : phase_q;
		acc_w  = start_s1 ? '0 : acc_q;
		base_w = start_s1 ? '0 : base_q;
		neg_n  = start_s1 ? 1'b0 : neg_q;
		cons_w = start_s1 ? '0 : cons_q;
		work   = 1'b1;
		tk_en   = 1'b0;
		tk_base = base_w;

		if (start_s1) begin
			if (signed_q && (ch_s1 == radp_pkg::CH_PLUS || ch_s1 == radp_pkg::CH_MINUS)) begin
				neg_n = (ch_s1 == radp_pkg::CH_MINUS);
				work  = 1'b0;
			end
		end else if (phase_q == PH_IDLE || phase_q == PH_DONE) begin
			work = 1'b0;
		end

		ph_n   = ph_w;
		acc_n  = acc_w;
		base_n = base_w;
		cons_n = (start_s1 && !work) ? cons_b1 : cons_w;

		if (work) begin
			unique case (ph_w)
				PH_PREFIX: begin
					if (radix_q == '0) begin
						if (ch_s1 == radp_pkg::CH_ZERO) begin
							cons_n = cons_b1;
							ph_n   = PH_ZERO_AUTO;
						end else begin
							tk_en   = 1'b1;
							tk_base = BASE_10;
						end
					end else if (radix_q == BASE_16 && ch_s1 == radp_pkg::CH_ZERO) begin
						base_n = BASE_16;
						cons_n = cons_b1;
						ph_n   = PH_ZERO_HEX;
					end else begin
						tk_en   = 1'b1;
						tk_base = radix_q;
					end
				end
				PH_ZERO_AUTO: begin
					if (is_x) begin
						ph_n = PH_ZERO_X;
					end else begin
						tk_en   = 1'b1;
						tk_base = BASE_8;
					end
				end
				PH_ZERO_X: begin
					if (dig < 7'd16) begin
						base_n = BASE_16;
						cons_n = cons_b2;
						acc_n  = {{(radp_pkg::VALUE_W-radp_pkg::DIGIT_W){1'b0}}, dig};
						ph_n   = PH_DIGITS;
					end else begin
						// "0x" without a hex digit: octal zero, x not consumed
						base_n = BASE_8;
						ph_n   = PH_DONE;
					end
				end
				PH_ZERO_HEX: begin
					if (is_x) begin
						cons_n = cons_b1;
						ph_n   = PH_DIGITS;
					end else begin
						tk_en = 1'b1;
					end
				end
				default: begin
					tk_en = 1'b1;
				end
			endcase

			// digit accept: below the base continues, anything else ends
			if (tk_en) begin
				base_n = tk_base;
				if (dig < {1'b0, tk_base}) begin
					acc_n  = prod[radp_pkg::VALUE_W-1:0]
						+ {{(radp_pkg::VALUE_W-radp_pkg::DIGIT_W){1'b0}}, dig};
					cons_n = cons_b1;
					ph_n   = PH_DIGITS;
				end else begin
					ph_n = PH_DONE;
				end
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= '0;
			signed_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				radp_pkg::REG_RADIX:  radix_q  <= cfg.data[radp_pkg::BASE_W-1:0];
				radp_pkg::REG_SIGNED: signed_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in.ready) begin
			v_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.ready && in.valid) begin
			ch_s1    <= in.ch;
			start_s1 <= in.start_req;
		end
	end

	// parser state, updated once per transfer into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			base_q  <= '0;
			neg_q   <= 1'b0;
			cons_q  <= '0;
		end else if (adv) begin
			phase_q <= ph_n;
			acc_q   <= acc_n;
			base_q  <= base_n;
			neg_q   <= neg_n;
			cons_q  <= cons_n;
		end
	end

	// result register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (out.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s2   <= acc_n;
			neg_s2   <= neg_n;
			ended_s2 <= (ph_n == PH_DONE) || (ph_n == PH_IDLE);
			cons_s2  <= cons_n;
			base_s2  <= base_n;
		end
	end

endmodule
`default_nettype wire

[tb/radix_integer_parser_tb.sv]
// testbench for radix_integer_parser: directed table plus random strings, checked by a predictor
`timescale 1ns / 100ps
module radix_integer_parser_tb;

	// one result per character transfer
	typedef struct packed {
		logic [radp_pkg::VALUE_W-1:0] value;
		logic                         ended;
		logic [radp_pkg::OFFS_W-1:0]  end_offset;
		logic [radp_pkg::BASE_W-1:0]  base_in_use;
	} parse_rslt_t;

	// where the predicted parse stands
	typedef enum logic [2:0] {
		PS_IDLE, PS_PREFIX, PS_ZERO_AUTO, PS_ZERO_X, PS_ZERO_HEX, PS_DIGITS, PS_DONE
	} parse_phase_t;

	// a directed row is either one character or a register setting
	typedef enum logic {ROW_CHAR, ROW_REGS} row_kind_t;

	// for ROW_REGS rows ch carries the radix and start carries signed_mode;
	// typed = 1 means the result columns are the expected result
	typedef struct packed {
		row_kind_t                    kind;
		logic [radp_pkg::CH_W-1:0]    ch;
		logic                         start;
		logic                         typed;
		logic [radp_pkg::VALUE_W-1:0] value;
		logic                         ended;
		logic [radp_pkg::OFFS_W-1:0]  offs;
		logic [radp_pkg::BASE_W-1:0]  base;
	} dir_row_t;

	localparam int DIR_ROWS = 28;
	localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
		// after reset, radix 0, unsigned: a character without start reports ended
		'{ROW_CHAR, 8'hFF, 1'b0, 1'b1, 64'd0, 1'b1, 16'd0, 6'd0},
		// auto-detected hex: 'x' is held back until a hex digit follows
		'{ROW_CHAR, radp_pkg::CH_ZERO, 1'b1, 1'b1, 64'd0, 1'b0, 16'd1, 6'd0},
		'{ROW_CHAR, radp_pkg::CH_X_LO, 1'b0, 1'b1, 64'd0, 1'b0, 16'd1, 6'd0},
		'{ROW_CHAR, "1", 1'b0, 1'b1, 64'd1, 1'b0, 16'd3, 6'd16},
		'{ROW_CHAR, radp_pkg::CH_F_UP, 1'b0, 1'b1, 64'd31, 1'b0, 16'd4, 6'd16},
		// pending hex prefix with no hex digit: falls back to octal zero
		'{ROW_CHAR, radp_pkg::CH_ZERO, 1'b1, 1'b0, 64'd0, 1'b0, 16'd0, 6'd0},
		'{ROW_CHAR, radp_pkg::CH_X_LO, 1'b0, 1'b0, 64'd0, 1'b0, 16'd0, 6'd0},
		'{ROW_CHAR, "g", 1'b0, 1'b1, 64'd0, 1'b1, 16'd1, 6'd8},
		// lone leading zero means octal, '8' ends it
		'{ROW_CHAR, radp_pkg::CH_ZERO, 1'b1, 1'b0, 64'd0, 1'b0, 16'd0, 6'd0},
		'{ROW_CHAR, "7", 1'b0, 1'b1, 64'd7, 1'b0, 16'd2, 6'd8},
		'{ROW_CHAR, "8", 1'b0, 1'b1, 64'd7, 1'b1, 16'd2, 6'd8},
		// a sign is not a digit in unsigned mode
		'{ROW_CHAR, radp_pkg::CH_MINUS, 1'b1, 1'b1, 64'd0, 1'b1, 16'd0, 6'd10},
		'{ROW_REGS, 8'd16, 1'b1, 1'b0, 64'd0, 1'b0, 16'd0, 6'd0},
		// radix 16, signed: "-0Xf" is minus fifteen
		'{ROW_CHAR, radp_pkg::CH_MINUS, 1'b1, 1'b1, 64'd0, 1'b0, 16'd1, 6'd0},
		'{ROW_CHAR, radp_pkg::CH_ZERO, 1'b0, 1'b1, 64'd0, 1'b0, 16'd2, 6'd16},
		'{ROW_CHAR, radp_pkg::CH_X_UP, 1'b0, 1'b1, 64'd0, 1'b0, 16'd3, 6'd16},
		'{ROW_CHAR, radp_pkg::CH_F_LO, 1'b0, 1'b1,
			64'hFFFF_FFFF_FFFF_FFF1, 1'b0, 16'd4, 6'd16},
		// sign followed by a non-digit
		'{ROW_CHAR, radp_pkg::CH_PLUS, 1'b1, 1'b0, 64'd0, 1'b0, 16'd0, 6'd0},
		'{ROW_CHAR, "q", 1'b0, 1'b1, 64'd0, 1'b1, 16'd1, 6'd16},
		// radix 16 takes "0x" even with nothing after it
		'{ROW_CHAR, radp_pkg::CH_ZERO, 1'b1, 1'b0, 64'd0, 1'b0, 16'd0, 6'd0},
		'{ROW_CHAR, radp_pkg::CH_X_LO, 1'b0, 1'b1, 64'd0, 1'b0, 16'd2, 6'd16},
		'{ROW_CHAR, "!", 1'b0, 1'b1, 64'd0, 1'b1, 16'd2, 6'd16},
		'{ROW_REGS, 8'd36, 1'b0, 1'b0, 64'd0, 1'b0, 16'd0, 6'd0},
		// base 36 still only knows digits up to f
		'{ROW_CHAR, radp_pkg::CH_F_LO, 1'b1, 1'b1, 64'd15, 1'b0, 16'd1, 6'd36},
		'{ROW_CHAR, radp_pkg::CH_F_UP, 1'b0, 1'b0, 64'd0, 1'b0, 16'd0, 6'd0},
		'{ROW_CHAR, "z", 1'b1, 1'b1, 64'd0, 1'b1, 16'd0, 6'd36},
		'{ROW_REGS, 8'd1, 1'b1, 1'b0, 64'd0, 1'b0, 16'd0, 6'd0},
		// radix 1 takes only '0'
		'{ROW_CHAR, "1", 1'b1, 1'b1, 64'd0, 1'b1, 16'd0, 6'd1}
	};

	logic clk;
	logic arst_n;
	logic rx_ready = 1'b0;

	radp_in_if  chr_if ();
	radp_out_if res_if ();
	radp_cfg_if reg_if ();

	assign res_if.ready = rx_ready;

	radix_integer_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (chr_if),
		.out    (res_if),
		.cfg    (reg_if)
	);

	// predicted parser state and the register copies it reads
	parse_phase_t                 num_phase;
	logic [radp_pkg::VALUE_W-1:0] num_acc;
	logic [radp_pkg::BASE_W-1:0]  num_base;
	logic                         num_neg;
	logic [radp_pkg::OFFS_W-1:0]  num_count;
	logic [radp_pkg::BASE_W-1:0]  cur_radix;
	logic                         cur_signed;

	parse_rslt_t parse_q [$];   // results owed by the block, oldest first

	int src_gap_pct;    // chance per cycle that the sender holds off
	int snk_stall_pct;  // chance per cycle that the receiver drops ready
	int fail_cnt;
	int strings_sent;
	int chars_sent;
	int results_checked;
	int reg_settings;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the handshakes hang
	initial begin
		#5_000_000;
		$display("[radix_integer_parser] ERROR");
		$finish;
	end

	// digit value of a raw byte, NO_DIGIT when it is not 0-9, a-f, A-F
	function automatic int unsigned char_digit(logic [radp_pkg::CH_W-1:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c) - int'("0");
		end else if (c >= "a" && c <= "f") begin
			return int'(c) - int'("a") + 10;
		end else if (c >= "A" && c <= "F") begin
			return int'(c) - int'("A") + 10;
		end
		return int'(radp_pkg::NO_DIGIT);
	endfunction

	function automatic logic is_x(logic [radp_pkg::CH_W-1:0] c);
		return c == radp_pkg::CH_X_LO || c == radp_pkg::CH_X_UP;
	endfunction

	// the end offset stops at its cap instead of wrapping
	function automatic void count_up();
		if (num_count < radp_pkg::OFFS_CAP) begin
			num_count++;
		end
	endfunction

	// a digit below the base extends the number, anything else ends the parse
	function automatic void accept_digit(logic [radp_pkg::CH_W-1:0] c);
		int unsigned d;
		d = char_digit(c);
		if (d < num_base) begin
			num_acc = num_acc * 64'(num_base) + 64'(d);
			count_up();
			num_phase = PS_DIGITS;
		end else begin
			num_phase = PS_DONE;
		end
	endfunction

	// advance the predicted parse by one character and give the result it shows
	function automatic parse_rslt_t parse_char(logic [radp_pkg::CH_W-1:0] c, logic start);
		parse_rslt_t r;
		logic        work;
		int unsigned d;
		work = 1'b1;
		if (start) begin
			num_acc   = '0;
			num_base  = '0;
			num_neg   = 1'b0;
			num_count = '0;
			num_phase = PS_PREFIX;
			// signed_mode is looked at here, on the first character only
			if (cur_signed && (c == radp_pkg::CH_PLUS || c == radp_pkg::CH_MINUS)) begin
				num_neg = (c == radp_pkg::CH_MINUS);
				count_up();
				work = 1'b0;
			end
		end else if (num_phase == PS_IDLE || num_phase == PS_DONE) begin
			work = 1'b0;
		end
		if (work) begin
			case (num_phase)
				PS_PREFIX: begin
					// radix is looked at on the first character after any sign
					if (cur_radix == 0) begin
						if (c == radp_pkg::CH_ZERO) begin
							count_up();
							num_phase = PS_ZERO_AUTO;
						end else begin
							num_base = 6'd10;
							accept_digit(c);
						end
					end else if (cur_radix == 6'd16 && c == radp_pkg::CH_ZERO) begin
						num_base = 6'd16;
						count_up();
						num_phase = PS_ZERO_HEX;
					end else begin
						num_base = cur_radix;
						accept_digit(c);
					end
				end
				PS_ZERO_AUTO: begin
					if (is_x(c)) begin
						num_phase = PS_ZERO_X;
					end else begin
						num_base = 6'd8;
						accept_digit(c);
					end
				end
				PS_ZERO_X: begin
					// the 'x' only counts once a hex digit confirms it
					d = char_digit(c);
					if (d < 16) begin
						num_base = 6'd16;
						count_up();
						count_up();
						num_acc = 64'(d);
						num_phase = PS_DIGITS;
					end else begin
						num_base = 6'd8;
						num_phase = PS_DONE;
					end
				end
				PS_ZERO_HEX: begin
					if (is_x(c)) begin
						count_up();
						num_phase = PS_DIGITS;
					end else begin
						accept_digit(c);
					end
				end
				default: begin
					accept_digit(c);
				end
			endcase
		end
		r.value       = num_neg ? 64'd0 - num_acc : num_acc;
		r.ended       = (num_phase == PS_DONE || num_phase == PS_IDLE);
		r.end_offset  = num_count;
		r.base_in_use = num_base;
		return r;
	endfunction

	// one character transfer; returns the predicted result once it is taken
	task automatic push_char(input logic [radp_pkg::CH_W-1:0] c, input logic start,
			output parse_rslt_t pred);
		while ($urandom_range(99) < src_gap_pct) begin
			chr_if.valid <= 1'b0;
			@(posedge clk);
		end
		chr_if.valid     <= 1'b1;
		chr_if.ch        <= c;
		chr_if.start_req <= start;
		@(posedge clk);
		while (!chr_if.ready) begin
			@(posedge clk);
		end
		pred = parse_char(c, start);
		chars_sent++;
	endtask

	// stop sending and wait for every owed result, then for the pipeline to settle
	task automatic drain();
		chr_if.valid <= 1'b0;
		while (parse_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// both registers, written back to back while the block is idle
	task automatic set_regs(input logic [radp_pkg::BASE_W-1:0] radix, input logic sgn);
		drain();
		reg_if.valid <= 1'b1;
		reg_if.index <= radp_pkg::REG_RADIX;
		reg_if.data  <= radix;
		@(posedge clk);
		while (!reg_if.ready) begin
			@(posedge clk);
		end
		cur_radix = radix;
		reg_if.index <= radp_pkg::REG_SIGNED;
		reg_if.data  <= {{(radp_pkg::CFG_DATA_W-1){1'b0}}, sgn};
		@(posedge clk);
		while (!reg_if.ready) begin
			@(posedge clk);
		end
		cur_signed = sgn;
		reg_if.valid <= 1'b0;
		reg_settings++;
	endtask

	// one random string: mostly well formed with random digits, sometimes noise
	task automatic send_string(output int sent);
		logic [radp_pkg::CH_W-1:0] str [$];
		parse_rslt_t               pred;
		int unsigned               eff;
		int unsigned               len;
		int unsigned               d;
		logic [radp_pkg::CH_W-1:0] b;
		if ($urandom_range(9) == 0) begin
			// noise: random bytes with random start marks
			len = $urandom_range(3, 1);
			repeat (len) begin
				push_char(8'($urandom_range(255)), 1'($urandom_range(1)), pred);
				parse_q.push_back(pred);
			end
			sent = len;
		end else begin
			// a sign now and then, also in unsigned mode where it ends the parse
			if ($urandom_range(3) == 0) begin
				str.push_back($urandom_range(1) ? radp_pkg::CH_MINUS : radp_pkg::CH_PLUS);
			end
			eff = (cur_radix == 0) ? 10 : cur_radix;
			case ($urandom_range(5))
				0: begin
					str.push_back(radp_pkg::CH_ZERO);
					str.push_back($urandom_range(1) ? radp_pkg::CH_X_LO : radp_pkg::CH_X_UP);
					if (cur_radix == 0 || cur_radix == 16) begin
						eff = 16;
					end
				end
				1: begin
					str.push_back(radp_pkg::CH_ZERO);
					if (cur_radix == 0) begin
						eff = 8;
					end
				end
				default: begin
				end
			endcase
			if (eff > 16) begin
				eff = 16;
			end
			// long bodies overflow 64 bits and wrap
			len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(12);
			repeat (len) begin
				if ($urandom_range(19) == 0) begin
					b = 8'($urandom_range(255));
				end else begin
					d = $urandom_range(eff - 1);
					if (d < 10) begin
						b = 8'(radp_pkg::CH_ZERO + d);
					end else begin
						b = 8'(($urandom_range(1) ? radp_pkg::CH_A_LO : radp_pkg::CH_A_UP)
							+ d - 10);
					end
				end
				str.push_back(b);
			end
			// up to two random trailing bytes: usually a terminator, at times a byte after the parse has ended
			repeat ($urandom_range(2)) begin
				str.push_back(8'($urandom_range(255)));
			end
			foreach (str[i]) begin
				push_char(str[i], i == 0, pred);
				parse_q.push_back(pred);
			end
			sent = str.size();
		end
	endtask

	// result side: random ready, each transfer compared with the oldest prediction
	always @(posedge clk) begin
		parse_rslt_t want;
		if (!arst_n) begin
			rx_ready <= 1'b0;
		end else begin
			if (res_if.valid && rx_ready) begin
				if (parse_q.size() == 0) begin
					$error("result transfer with nothing owed: value %h", res_if.value);
					fail_cnt++;
				end else begin
					want = parse_q.pop_front();
					results_checked++;
					if (res_if.value !== want.value) begin
						$error("value: expected %h, got %h", want.value, res_if.value);
						fail_cnt++;
					end
					if (res_if.ended !== want.ended) begin
						$error("ended: expected %0b, got %0b", want.ended, res_if.ended);
						fail_cnt++;
					end
					if (res_if.end_offset !== want.end_offset) begin
						$error("end_offset: expected %0d, got %0d",
							want.end_offset, res_if.end_offset);
						fail_cnt++;
					end
					if (res_if.base_in_use !== want.base_in_use) begin
						$error("base_in_use: expected %0d, got %0d",
							want.base_in_use, res_if.base_in_use);
						fail_cnt++;
					end
				end
			end
			rx_ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	initial begin
		parse_rslt_t pred;
		parse_rslt_t typed_rslt;
		dir_row_t    row;
		int          n;
		int          sent;
		arst_n           <= 1'b0;
		chr_if.valid     <= 1'b0;
		chr_if.ch        <= '0;
		chr_if.start_req <= 1'b0;
		reg_if.valid     <= 1'b0;
		reg_if.index     <= radp_pkg::REG_RADIX;
		reg_if.data      <= '0;
		num_phase  = PS_IDLE;
		num_acc    = '0;
		num_base   = '0;
		num_neg    = 1'b0;
		num_count  = '0;
		cur_radix  = '0;
		cur_signed = 1'b0;
		fail_cnt        = 0;
		strings_sent    = 0;
		chars_sent      = 0;
		results_checked = 0;
		reg_settings    = 0;
		// first stretch: sender idles a little, receiver a lot
		src_gap_pct   = 13;
		snk_stall_pct = 55;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, starting from the reset register values
		for (int k = 0; k < DIR_ROWS; k++) begin
			row = DIR_TAB[k];
			if (row.kind == ROW_REGS) begin
				set_regs(row.ch[radp_pkg::BASE_W-1:0], row.start);
			end else begin
				push_char(row.ch, row.start, pred);
				if (row.typed) begin
					typed_rslt.value       = row.value;
					typed_rslt.ended       = row.ended;
					typed_rslt.end_offset  = row.offs;
					typed_rslt.base_in_use = row.base;
					parse_q.push_back(typed_rslt);
				end else begin
					parse_q.push_back(pred);
				end
			end
		end

		// random strings: three stretches with different idling, three register settings in each
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_gap_pct   = 13;
					snk_stall_pct = 55;
				end
				1: begin
					src_gap_pct   = 55;
					snk_stall_pct = 13;
				end
				default: begin
					src_gap_pct   = 0;
					snk_stall_pct = 0;
				end
			endcase
			repeat (3) begin
				// radix 0 is weighted up since it has prefix handling
				case ($urandom_range(9))
					0, 1, 2: n = 0;
					3:       n = 16;
					4:       n = 10;
					5:       n = 8;
					6:       n = 2;
					7:       n = 36;
					8:       n = 1;
					default: n = $urandom_range(36);
				endcase
				set_regs(radp_pkg::BASE_W'(n), 1'($urandom_range(1)));
				n = 0;
				while (n < 42) begin
					send_string(sent);
					n += sent;
					strings_sent++;
					// let the block run dry now and then
					if ($urandom_range(19) == 0) begin
						drain();
					end
				end
			end
		end

		drain();
		repeat (4) @(posedge clk);
		$display("covered %0d strings, %0d characters, %0d results checked",
			strings_sent, chars_sent, results_checked);
		$display("under %0d register settings, with prefixes, signs and stalls on both sides",
			reg_settings);
		if (fail_cnt == 0) begin
			$display("[radix_integer_parser] OK");
		end else begin
			$display("[radix_integer_parser] ERROR");
		end
		$finish;
	end

endmodule
